// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define PEDC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pedc assertion failed");

// Checks that a condition implies a consequence at the next clock edge.
`define PEDC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("pedc assertion failed");

`endif

// File: rtl/pedc_pkg.sv
// Types, character constants and helpers of the percent escape decoder.
package pedc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cnt_t;
  typedef logic [3:0] nib_t;

  localparam byte_t PctChar    = 8'h25;
  localparam byte_t Char0      = 8'h30;
  localparam byte_t Char9      = 8'h39;
  localparam byte_t CharLowA   = 8'h61;
  localparam byte_t CharLowF   = 8'h66;
  localparam byte_t CharUpA    = 8'h41;
  localparam byte_t CharUpF    = 8'h46;
  localparam byte_t HexTen     = 8'h0a;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  // One decoded run: up to three bytes, emitted in order b0, b1, b2.
  typedef struct packed {
    byte_t b0;
    byte_t b1;
    byte_t b2;
    cnt_t  cnt;
  } run_t;

  typedef struct packed {
    logic valid;
    nib_t nib;
  } hex_t;

  function automatic hex_t hex_decode(input byte_t ch);
    hex_t  res;
    byte_t d;
    res = '0;
    d   = '0;
    if (ch >= Char0 && ch <= Char9) begin
      d = ch - Char0;
      res.valid = 1'b1;
    end else if (ch >= CharLowA && ch <= CharLowF) begin
      d = ch - CharLowA + HexTen;
      res.valid = 1'b1;
    end else if (ch >= CharUpA && ch <= CharUpF) begin
      d = ch - CharUpA + HexTen;
      res.valid = 1'b1;
    end
    res.nib = d[3:0];
    return res;
  endfunction

endpackage

// File: rtl/pedc_front.sv
// Front end: accepts text bytes, tracks the escape state and builds output runs.
`include "assert_macros.svh"
module pedc_front import pedc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  byte_t text_byte_i,
  input  logic  end_of_message_i,
  input  logic  full_i,
  output logic  run_push_o,
  output run_t  run_o
);

  phase_e phase_q, phase_d;
  byte_t  hd_q, hd_d;
  logic   accept;
  hex_t   cur_hex;
  hex_t   hd_hex;
  run_t   run;

  assign accept  = push_i && !full_i;
  assign cur_hex = hex_decode(text_byte_i);
  assign hd_hex  = hex_decode(hd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hd_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hd_q    <= hd_d;
    end
  end

  always_comb begin
    phase_d = PhIdle;
    hd_d    = hd_q;
    run     = '0;
    unique case (phase_q)
      PhPct: begin
        if (cur_hex.valid) begin
          hd_d    = text_byte_i;
          phase_d = PhDigit;
        end else if (text_byte_i == PctChar) begin
          run.b0  = PctChar;
          run.cnt = 2'd1;
        end else begin
          run.b0  = PctChar;
          run.b1  = text_byte_i;
          run.cnt = 2'd2;
        end
      end
      PhDigit: begin
        if (cur_hex.valid) begin
          run.b0  = {hd_hex.nib, cur_hex.nib};
          run.cnt = 2'd1;
        end else begin
          run.b0  = PctChar;
          run.b1  = hd_q;
          run.b2  = text_byte_i;
          run.cnt = 2'd3;
        end
      end
      default: begin
        if (text_byte_i == PctChar) begin
          phase_d = PhPct;
        end else begin
          run.b0  = text_byte_i;
          run.cnt = 2'd1;
        end
      end
    endcase
    if (end_of_message_i) begin
      phase_d = PhIdle;
    end
    if (phase_d == PhIdle) begin
      hd_d = '0;
    end
  end

  assign run_push_o = accept && (run.cnt != 2'd0);
  assign run_o      = run;

  `PEDC_ASSERT_NEXT(a_eom_idle, clk_i, rst_ni, accept && end_of_message_i, phase_q == PhIdle)
  `PEDC_ASSERT(a_no_push_full, clk_i, rst_ni, !(run_push_o && full_i))

endmodule

// File: rtl/pedc_fifo.sv
// Short run queue between the front end and the back end.
`include "assert_macros.svh"
module pedc_fifo import pedc_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  run_t wdata_i,
  input  logic rd_i,
  output run_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  run_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PEDC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(Depth))

endmodule

// File: rtl/pedc_back.sv
// Back end: walks through each queued run and emits its bytes one at a time.
`include "assert_macros.svh"
module pedc_back import pedc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  run_valid_i,
  input  run_t  run_i,
  output logic  run_pop_o,
  input  logic  pop_i,
  output logic  empty_o,
  output byte_t decoded_byte_o,
  output logic  last_of_run_o
);

  cnt_t idx_q;
  logic last;

  assign empty_o = !run_valid_i;
  assign last    = (idx_q == run_i.cnt - 2'd1);

  always_comb begin
    case (idx_q)
      2'd0:    decoded_byte_o = run_i.b0;
      2'd1:    decoded_byte_o = run_i.b1;
      default: decoded_byte_o = run_i.b2;
    endcase
  end

  assign last_of_run_o = last;
  assign run_pop_o     = pop_i && run_valid_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (pop_i && run_valid_i) begin
      idx_q <= last ? '0 : idx_q + 2'd1;
    end
  end

  `PEDC_ASSERT(a_idx_in_run, clk_i, rst_ni, !run_valid_i || (idx_q < run_i.cnt))

endmodule

// File: rtl/percent_escape_decoder_core.sv
// Top level of the percent escape decoder.
// Usage: text bytes enter through a queue-style port; an item is taken at a
// rising edge with push high and full low. Each item carries one text byte
// and an end-of-message flag, and causes zero to three decoded bytes.
// Decoded bytes leave through a queue-style port: while empty is low the
// oldest byte is on decoded_byte_o, and last_of_run_o marks the final byte
// caused by one input item; it is taken at a rising edge with pop high.
// A run is registered in the run queue when its item is taken; runs leave in order.
// Throughput: one item per cycle on the input side while full is low; the output
// side emits one byte per cycle while pop is high, so an item that yields three
// bytes holds the back end while the run queue absorbs the following items.
// Reset clears the escape state and the run queue; nothing is pending.
// When the receiver stalls, the run queue fills and full rises, after which
// no further item is taken until the receiver pops the final byte of a run.
module percent_escape_decoder_core import pedc_pkg::*; #(
  parameter int RunDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  decoded_byte_o,
  output logic        last_of_run_o
);

  logic run_push;
  run_t run_w;
  run_t run_r;
  logic run_pop;
  logic q_empty;

  pedc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .text_byte_i      (text_byte_i),
    .end_of_message_i (end_of_message_i),
    .full_i           (full),
    .run_push_o       (run_push),
    .run_o            (run_w)
  );

  pedc_fifo #(
    .Depth (RunDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (run_push),
    .wdata_i (run_w),
    .rd_i    (run_pop),
    .rdata_o (run_r),
    .full_o  (full),
    .empty_o (q_empty)
  );

  pedc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_valid_i    (!q_empty),
    .run_i          (run_r),
    .run_pop_o      (run_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .decoded_byte_o (decoded_byte_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

// File: bench/percent_escape_decoder_core_test.sv
// Self-checking testbench of the percent escape decoder core, with its own decoder model.
module percent_escape_decoder_core_test;
  import pedc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 90;
  localparam int DrainCycles = 10;

  typedef struct {
    byte_t text;
    logic  eom;
  } text_item_t;

  typedef struct {
    byte_t data;
    logic  last;
  } decoded_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_byte_i = 8'h00;
  logic       end_of_message_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] decoded_byte_o;
  logic       last_of_run_o;

  text_item_t pending_text[$];
  decoded_t   expected_out[$];

  phase_e esc_phase = PhIdle;
  byte_t  first_digit = '0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic took_item = 1'b0;
  logic hold_request = 1'b0;
  logic hold_rx = 1'b0;

  int errors = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int bytes_checked = 0;
  int full_cycles = 0;

  percent_escape_decoder_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .text_byte_i      (text_byte_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .decoded_byte_o   (decoded_byte_o),
    .last_of_run_o    (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  function automatic logic hex_nibble(input byte_t ch, output nib_t nib);
    logic letter;
    logic digit;
    digit  = (ch >= Char0) && (ch <= Char9);
    letter = ((ch >= CharLowA) && (ch <= CharLowF)) || ((ch >= CharUpA) && (ch <= CharUpF));
    nib    = letter ? ch[3:0] + 4'd9 : ch[3:0];
    return digit || letter;
  endfunction

  task automatic predict_item(input byte_t ch, input logic eom);
    byte_t run_q[$];
    nib_t  lo;
    nib_t  hi;
    logic  lo_ok;
    lo_ok = hex_nibble(ch, lo);
    hi    = '0;
    case (esc_phase)
      PhPct: begin
        if (lo_ok) begin
          first_digit = ch;
          esc_phase   = PhDigit;
        end else begin
          run_q.push_back(PctChar);
          if (ch != PctChar) run_q.push_back(ch);
          esc_phase = PhIdle;
        end
      end
      PhDigit: begin
        if (lo_ok) begin
          void'(hex_nibble(first_digit, hi));
          run_q.push_back({hi, lo});
        end else begin
          run_q.push_back(PctChar);
          run_q.push_back(first_digit);
          run_q.push_back(ch);
        end
        esc_phase = PhIdle;
      end
      default: begin
        if (ch == PctChar) esc_phase = PhPct;
        else run_q.push_back(ch);
      end
    endcase
    if (eom) esc_phase = PhIdle;
    if (esc_phase == PhIdle) first_digit = '0;
    foreach (run_q[k]) begin
      expected_out.push_back('{data: run_q[k], last: (k == run_q.size() - 1)});
    end
  endtask

  function automatic logic rand_eom();
    return $urandom_range(99) < 8;
  endfunction

  function automatic byte_t hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return Char0 + byte_t'(v);
    if ($urandom_range(1) == 0) return CharLowA + byte_t'(v - 10);
    return CharUpA + byte_t'(v - 10);
  endfunction

  function automatic byte_t non_hex_char();
    byte_t b;
    nib_t  unused_nib;
    do begin
      b = byte_t'($urandom_range(255));
    end while (hex_nibble(b, unused_nib));
    return b;
  endfunction

  function automatic byte_t literal_char();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(255));
    end while (b == PctChar);
    return b;
  endfunction

  task automatic add_item(input byte_t ch, input logic eom);
    pending_text.push_back('{text: ch, eom: eom});
  endtask

  task automatic add_random_run();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      add_item(PctChar, rand_eom());
      add_item(hex_char(), rand_eom());
      add_item(hex_char(), rand_eom());
    end else if (r < 40) begin
      add_item(PctChar, rand_eom());
      add_item(PctChar, rand_eom());
    end else if (r < 50) begin
      add_item(PctChar, rand_eom());
      add_item(non_hex_char(), rand_eom());
    end else if (r < 60) begin
      add_item(PctChar, rand_eom());
      add_item(hex_char(), rand_eom());
      add_item(non_hex_char(), rand_eom());
    end else if (r < 90) begin
      add_item(literal_char(), rand_eom());
    end else begin
      add_item(byte_t'($urandom_range(255)), rand_eom());
    end
  endtask

  task automatic add_random_items(input int count);
    int target;
    target = pending_text.size() + count;
    while (pending_text.size() < target) add_random_run();
  endtask

  task automatic wait_drained();
    while (pending_text.size() != 0 || push || expected_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_directed_items();
    add_item(8'h00, 1'b0);
    add_item(8'hff, 1'b1);
    add_item(PctChar, 1'b0);
    add_item(8'h34, 1'b0);
    add_item(8'h31, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(CharLowF, 1'b0);
    add_item(CharUpF, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(Char0, 1'b0);
    add_item(Char9, 1'b1);
    add_item(PctChar, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(8'h47, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(8'h34, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(PctChar, 1'b1);
    add_item(PctChar, 1'b0);
    add_item(CharUpA, 1'b1);
    add_item(8'h60, 1'b0);
    add_item(PctChar, 1'b0);
    add_item(CharLowA, 1'b0);
    add_item(8'h2f, 1'b1);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_rx = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_rx = 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    decoded_t want;
    if (rst_ni) begin
      took_item = push && !full;
      if (full) full_cycles++;
      if (took_item) begin
        predict_item(text_byte_i, end_of_message_i);
        items_taken++;
      end
      if (pop && !empty) begin
        bytes_checked++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", decoded_byte_o));
        end else begin
          want = expected_out.pop_front();
          if (decoded_byte_o !== want.data) begin
            report_mismatch($sformatf("decoded_byte %02h, expected %02h",
                                      decoded_byte_o, want.data));
          end
          if (last_of_run_o !== want.last) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      last_of_run_o, want.last));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver_proc
    text_item_t next_item;
    if (rst_ni && (!push || took_item)) begin
      if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_text.pop_front();
        push <= 1'b1;
        text_byte_i <= next_item.text;
        end_of_message_i <= next_item.eom;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_directed_items();
    wait_drained();

    add_random_items(70);
    wait_drained();

    @(posedge clk_i);
    send_idle_pct = 69;
    add_random_items(70);
    wait_drained();

    @(posedge clk_i);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    add_random_items(70);
    wait_drained();

    @(posedge clk_i);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    add_random_items(70);
    wait_drained();

    @(posedge clk_i);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_request = 1'b1;
    add_random_items(30);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_out.size()));
    end
    $display("Covered %0d text items and %0d decoded bytes across directed, idle, stall",
             items_taken, bytes_checked);
    $display("and back-pressure phases; input was held off by full for %0d cycles.",
             full_cycles);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
